// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/swsb_pkg.sv
package swsb_pkg;

    localparam int MAX_WINDOW_DEF = 512;
    localparam int PRICE_BITS_DEF = 24;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int WLEN_BITS     = 10;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 12;

    // chunk width of the shared multiply-accumulate in the back end
    localparam int MAC_CHUNK = 16;

    // depth of the job queue between front and back
    localparam int JOB_DEPTH = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_COEF = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_COEF = 2'd2;

    localparam logic [WLEN_BITS-1:0] WINDOW_LEN_RST = 10'd300;
    localparam logic [COEF_BITS-1:0] INNER_COEF_RST = 16'd4096;
    localparam logic [COEF_BITS-1:0] OUTER_COEF_RST = 16'd8192;

    typedef struct packed {
        logic [WLEN_BITS-1:0] window_len;
        logic [COEF_BITS-1:0] inner_coef;
        logic [COEF_BITS-1:0] outer_coef;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_UPDATE
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NQ,
        B_SS,
        B_PREP,
        B_DIV,
        B_SQRT,
        B_BAND,
        B_OUT
    } t_back_state;

endpackage

// File: src/swsb_front.sv
module swsb_front #(
    parameter int MAX_WINDOW = swsb_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = swsb_pkg::PRICE_BITS_DEF,
    localparam int NB   = $clog2(MAX_WINDOW + 1),
    localparam int LG   = $clog2(MAX_WINDOW),
    localparam int SUMW = PRICE_BITS + LG,
    localparam int QW   = 2 * PRICE_BITS + LG,
    localparam int JW   = 2 * PRICE_BITS + SUMW + QW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic [NB-1:0]         i_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PRICE_BITS-1:0] i_open,
    input  logic [PRICE_BITS-1:0] i_close,
    output logic                  o_push,
    output logic [JW-1:0]         o_job,
    input  logic                  i_full
);

    localparam int PTRW = LG;

    swsb_pkg::t_front_state r_state, n_state;

    logic [PRICE_BITS-1:0]   r_ring [MAX_WINDOW];
    logic [PTRW-1:0]         r_ptr;
    logic [NB-1:0]           r_fill;
    logic [SUMW-1:0]         r_sum;
    logic [QW-1:0]           r_sq;
    logic [PRICE_BITS-1:0]   r_open, r_close, r_old;
    logic [2*PRICE_BITS-1:0] r_sq_new, r_sq_old;

    logic accept, win_full, advance, ring_we;

    assign accept   = i_valid && !o_stall;
    assign win_full = r_fill >= i_n;
    assign o_job    = {r_open, r_close, r_sum, r_sq};

    always_comb begin
        n_state = r_state;
        case (r_state)
            swsb_pkg::F_IDLE:   if (accept) n_state = swsb_pkg::F_SQUARE;
            swsb_pkg::F_SQUARE: n_state = swsb_pkg::F_UPDATE;
            swsb_pkg::F_UPDATE: if (!win_full || !i_full) n_state = swsb_pkg::F_IDLE;
            default:            n_state = swsb_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != swsb_pkg::F_IDLE);
        advance = (r_state == swsb_pkg::F_UPDATE) && (!win_full || !i_full);
        o_push  = (r_state == swsb_pkg::F_UPDATE) && win_full && !i_full;
        ring_we = advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swsb_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample ring, read of the oldest entry on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= r_ring[r_ptr];
        end
        if (ring_we) begin
            r_ring[r_ptr] <= r_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_open  <= i_open;
            r_close <= i_close;
        end
        if (r_state == swsb_pkg::F_SQUARE) begin
            r_sq_new <= r_close * r_close;
            r_sq_old <= r_old * r_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
        end else if (advance) begin
            if (win_full) begin
                r_sum <= r_sum - SUMW'(r_old) + SUMW'(r_close);
                r_sq  <= r_sq - QW'(r_sq_old) + QW'(r_sq_new);
            end else begin
                r_fill <= r_fill + NB'(1);
                r_sum  <= r_sum + SUMW'(r_close);
                r_sq   <= r_sq + QW'(r_sq_new);
            end
            if ((NB'(r_ptr) + NB'(1)) >= i_n) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= r_ptr + PTRW'(1);
            end
        end
    end

endmodule

// File: src/swsb_fifo.sv
`include "assert_macros.svh"

module swsb_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int DEPTH = swsb_pkg::JOB_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + AW'(1);
            if (i_pop)  r_rd <= r_rd + AW'(1);
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "job queue overflow")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "job queue underflow")

endmodule

// File: src/swsb_back.sv
`include "assert_macros.svh"

module swsb_back #(
    parameter int MAX_WINDOW = swsb_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = swsb_pkg::PRICE_BITS_DEF,
    localparam int NB    = $clog2(MAX_WINDOW + 1),
    localparam int LG    = $clog2(MAX_WINDOW),
    localparam int SUMW  = PRICE_BITS + LG,
    localparam int QW    = 2 * PRICE_BITS + LG,
    localparam int JW    = 2 * PRICE_BITS + SUMW + QW,
    localparam int BANDW = PRICE_BITS + 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NB-1:0]           i_n,
    input  swsb_pkg::t_cfg          i_cfg,
    input  logic [JW-1:0]           i_job,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PRICE_BITS-1:0]   o_open_echo,
    output logic [PRICE_BITS-1:0]   o_close_echo,
    output logic [PRICE_BITS-1:0]   o_window_mean,
    output logic [PRICE_BITS-1:0]   o_window_sigma,
    output logic signed [BANDW-1:0] o_outer_low,
    output logic signed [BANDW-1:0] o_inner_low,
    output logic signed [BANDW-1:0] o_inner_high,
    output logic signed [BANDW-1:0] o_outer_high
);

    localparam int P     = PRICE_BITS;
    localparam int DW    = QW + NB;
    localparam int QTW   = 2 * P;
    localparam int DENW  = 2 * NB;
    localparam int CH    = swsb_pkg::MAC_CHUNK;
    localparam int QCH   = (QW + CH - 1) / CH;
    localparam int SCH   = (SUMW + CH - 1) / CH;
    localparam int QPAD  = QCH * CH;
    localparam int SPAD  = SCH * CH;
    localparam int CNTW  = $clog2(P);
    localparam int CB    = swsb_pkg::COEF_BITS;
    localparam int CF    = swsb_pkg::COEF_FRAC;
    localparam int PRODW = CB + P;
    localparam int OFFW  = PRODW + 1 - CF;
    localparam int EXTW  = BANDW + 2;
    localparam logic [PRODW:0] ROUND = (PRODW+1)'(1) << (CF - 1);
    localparam logic signed [EXTW-1:0] BAND_HI = {3'b000, {(BANDW-1){1'b1}}};
    localparam logic signed [EXTW-1:0] BAND_LO = ~BAND_HI;

    swsb_pkg::t_back_state r_state, n_state;

    logic [CNTW-1:0]   r_cnt;
    logic [P-1:0]      r_open, r_close;
    logic [SUMW-1:0]   r_sum;
    logic [QPAD-1:0]   r_qsh;
    logic [SPAD-1:0]   r_ssh;
    logic [DW-1:0]     r_acc_nq, r_acc_ss;
    logic [DENW-1:0]   r_den, r_drem;
    logic [QTW-1:0]    r_dq;
    logic [NB-1:0]     r_mrem;
    logic [P-1:0]      r_mq;
    logic [P+1:0]      r_srem;
    logic [P-1:0]      r_root;
    logic [OFFW-1:0]   r_off_in, r_off_out;

    logic              out_free, load_out, last_step;
    logic [CH-1:0]     mac_a;
    logic [SUMW-1:0]   mac_b;
    logic [CH+SUMW-1:0] mac_prod;
    logic [DW-1:0]     diff;
    logic [SUMW:0]     mnum;
    logic [DENW:0]     t1, t2;
    logic [DENW-1:0]   rem1, rem2;
    logic              qb1, qb2;
    logic [NB:0]       tm;
    logic [NB-1:0]     mrem_n;
    logic              mqb;
    logic [P+3:0]      st, trial;
    logic [P+1:0]      srem_n;
    logic [P-1:0]      root_n;
    logic [CB-1:0]     band_coef;
    logic [PRODW:0]    band_rnd;
    logic signed [EXTW-1:0] mean_x, off_in_x, off_out_x;

    function automatic logic [BANDW-1:0] sat_band(input logic signed [EXTW-1:0] v);
        logic signed [EXTW-1:0] c;
        c = v;
        if (v > BAND_HI) begin
            c = BAND_HI;
        end else if (v < BAND_LO) begin
            c = BAND_LO;
        end
        return c[BANDW-1:0];
    endfunction

    assign out_free  = !o_valid || !i_stall;
    assign last_step = (r_cnt == CNTW'(P - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            swsb_pkg::B_IDLE: if (!i_empty) n_state = swsb_pkg::B_NQ;
            swsb_pkg::B_NQ:   if (r_cnt == CNTW'(QCH - 1)) n_state = swsb_pkg::B_SS;
            swsb_pkg::B_SS:   if (r_cnt == CNTW'(SCH - 1)) n_state = swsb_pkg::B_PREP;
            swsb_pkg::B_PREP: n_state = swsb_pkg::B_DIV;
            swsb_pkg::B_DIV:  if (last_step) n_state = swsb_pkg::B_SQRT;
            swsb_pkg::B_SQRT: if (last_step) n_state = swsb_pkg::B_BAND;
            swsb_pkg::B_BAND: if (r_cnt == CNTW'(1)) n_state = swsb_pkg::B_OUT;
            swsb_pkg::B_OUT:  if (out_free) n_state = swsb_pkg::B_IDLE;
            default:          n_state = swsb_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == swsb_pkg::B_IDLE) && !i_empty;
        load_out = (r_state == swsb_pkg::B_OUT) && out_free;
    end

    // shared chunk multiplier: n times sum of squares, then sum times sum
    always_comb begin
        if (r_state == swsb_pkg::B_NQ) begin
            mac_a = r_qsh[QPAD-1 -: CH];
            mac_b = SUMW'(i_n);
        end else begin
            mac_a = r_ssh[SPAD-1 -: CH];
            mac_b = r_sum;
        end
        mac_prod = (CH+SUMW)'(mac_a) * (CH+SUMW)'(mac_b);
    end

    always_comb begin
        diff = (r_acc_nq >= r_acc_ss) ? (r_acc_nq - r_acc_ss) : '0;
        mnum = (SUMW+1)'(r_sum) + (SUMW+1)'(i_n >> 1);
    end

    // two restoring steps of the variance divider, one of the mean divider
    always_comb begin
        t1 = {r_drem, r_dq[QTW-1]};
        if (t1 >= {1'b0, r_den}) begin
            rem1 = DENW'(t1 - {1'b0, r_den});
            qb1  = 1'b1;
        end else begin
            rem1 = t1[DENW-1:0];
            qb1  = 1'b0;
        end
        t2 = {rem1, r_dq[QTW-2]};
        if (t2 >= {1'b0, r_den}) begin
            rem2 = DENW'(t2 - {1'b0, r_den});
            qb2  = 1'b1;
        end else begin
            rem2 = t2[DENW-1:0];
            qb2  = 1'b0;
        end
        tm = {r_mrem, r_mq[P-1]};
        if (tm >= {1'b0, i_n}) begin
            mrem_n = NB'(tm - {1'b0, i_n});
            mqb    = 1'b1;
        end else begin
            mrem_n = tm[NB-1:0];
            mqb    = 1'b0;
        end
    end

    // one root bit per cycle
    always_comb begin
        st    = {r_srem, r_dq[QTW-1 -: 2]};
        trial = (P+4)'({r_root, 2'b01});
        if (st >= trial) begin
            srem_n = (P+2)'(st - trial);
            root_n = {r_root[P-2:0], 1'b1};
        end else begin
            srem_n = (P+2)'(st);
            root_n = {r_root[P-2:0], 1'b0};
        end
    end

    always_comb begin
        band_coef = (r_cnt == '0) ? i_cfg.inner_coef : i_cfg.outer_coef;
        band_rnd  = (PRODW+1)'((PRODW)'(band_coef) * (PRODW)'(r_root)) + ROUND;
        mean_x    = EXTW'(r_mq);
        off_in_x  = EXTW'(r_off_in);
        off_out_x = EXTW'(r_off_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swsb_pkg::B_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            swsb_pkg::B_IDLE: begin
                if (o_pop) begin
                    {r_open, r_close, r_sum} <= i_job[JW-1:QW];
                    r_qsh    <= QPAD'(i_job[QW-1:0]);
                    r_ssh    <= SPAD'(i_job[QW+SUMW-1:QW]);
                    r_acc_nq <= '0;
                    r_acc_ss <= '0;
                end
            end
            swsb_pkg::B_NQ: begin
                r_acc_nq <= (r_acc_nq << CH) + DW'(mac_prod);
                r_qsh    <= r_qsh << CH;
            end
            swsb_pkg::B_SS: begin
                r_acc_ss <= (r_acc_ss << CH) + DW'(mac_prod);
                r_ssh    <= r_ssh << CH;
            end
            swsb_pkg::B_PREP: begin
                r_den  <= DENW'(i_n * (i_n - NB'(1)));
                r_drem <= DENW'(diff[DW-1:QTW]);
                r_dq   <= diff[QTW-1:0];
                r_mrem <= NB'(mnum[SUMW:P]);
                r_mq   <= mnum[P-1:0];
                r_srem <= '0;
                r_root <= '0;
            end
            swsb_pkg::B_DIV: begin
                r_drem <= rem2;
                r_dq   <= {r_dq[QTW-3:0], qb1, qb2};
                r_mrem <= mrem_n;
                r_mq   <= {r_mq[P-2:0], mqb};
            end
            swsb_pkg::B_SQRT: begin
                r_srem <= srem_n;
                r_root <= root_n;
                r_dq   <= r_dq << 2;
            end
            swsb_pkg::B_BAND: begin
                if (r_cnt == '0) begin
                    r_off_in <= band_rnd[PRODW:CF];
                end else begin
                    r_off_out <= band_rnd[PRODW:CF];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_open_echo    <= r_open;
            o_close_echo   <= r_close;
            o_window_mean  <= r_mq;
            o_window_sigma <= r_root;
            o_outer_low    <= sat_band(mean_x - off_out_x);
            o_inner_low    <= sat_band(mean_x - off_in_x);
            o_inner_high   <= sat_band(mean_x + off_in_x);
            o_outer_high   <= sat_band(mean_x + off_out_x);
        end
    end

    `ASSERT_CLK(a_out_loaded, i_clk, i_rst_n, (r_state == swsb_pkg::B_OUT) && out_free |=> o_valid, "result not presented")

endmodule

// File: src/sliding_window_sigma_bands_core.sv
// rolling mean, sample standard deviation and two pairs of sigma bands over the
// last window_len close prices (unsigned Q16.8 in, signed Q20.8 bands out).
// the first window_len beats after reset or after a window_len write only fill
// the window and give no result; after that every input beat gives exactly one
// result beat, computed over the window held before that beat, and then
// replaces the oldest sample. the front end takes each input beat through a
// ring read, squaring and sum update, stalling its input meanwhile; the back
// end takes one job at a time through the chunked multiplies, the bit-serial
// variance divider and square root and the band products, and pops the next
// job once the last result is loaded; a window_len write empties the window.
// a two-entry job queue lets the front keep accepting while a result waits.
// the user writes configuration only while idle; the block does not enforce it.
module sliding_window_sigma_bands_core #(
    parameter int MAX_WINDOW = swsb_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = swsb_pkg::PRICE_BITS_DEF,
    localparam int BANDW = PRICE_BITS + 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [swsb_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [swsb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [PRICE_BITS-1:0]                i_open_price,
    input  logic [PRICE_BITS-1:0]                i_close_price,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [PRICE_BITS-1:0]                o_open_echo,
    output logic [PRICE_BITS-1:0]                o_close_echo,
    output logic [PRICE_BITS-1:0]                o_window_mean,
    output logic [PRICE_BITS-1:0]                o_window_sigma,
    output logic signed [BANDW-1:0]              o_outer_low,
    output logic signed [BANDW-1:0]              o_inner_low,
    output logic signed [BANDW-1:0]              o_inner_high,
    output logic signed [BANDW-1:0]              o_outer_high
);

    localparam int NB   = $clog2(MAX_WINDOW + 1);
    localparam int LG   = $clog2(MAX_WINDOW);
    localparam int SUMW = PRICE_BITS + LG;
    localparam int QW   = 2 * PRICE_BITS + LG;
    localparam int JW   = 2 * PRICE_BITS + SUMW + QW;

    swsb_pkg::t_cfg r_cfg;

    logic [NB-1:0] eff_n;
    logic          win_clear;
    logic          job_push, job_pop, job_full, job_empty;
    logic [JW-1:0] job_in, job_out;

    // register file, window_len write also empties the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_len <= swsb_pkg::WINDOW_LEN_RST;
            r_cfg.inner_coef <= swsb_pkg::INNER_COEF_RST;
            r_cfg.outer_coef <= swsb_pkg::OUTER_COEF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swsb_pkg::REG_WINDOW_LEN: r_cfg.window_len <= i_cfg_data[swsb_pkg::WLEN_BITS-1:0];
                swsb_pkg::REG_INNER_COEF: r_cfg.inner_coef <= i_cfg_data[swsb_pkg::COEF_BITS-1:0];
                swsb_pkg::REG_OUTER_COEF: r_cfg.outer_coef <= i_cfg_data[swsb_pkg::COEF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign win_clear = i_cfg_we && (i_cfg_idx == swsb_pkg::REG_WINDOW_LEN);

    // window length clamped to 2..MAX_WINDOW
    always_comb begin
        eff_n = NB'(r_cfg.window_len);
        if (r_cfg.window_len < swsb_pkg::WLEN_BITS'(2)) begin
            eff_n = NB'(2);
        end else if (int'(r_cfg.window_len) > MAX_WINDOW) begin
            eff_n = NB'(MAX_WINDOW);
        end
    end

    swsb_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (win_clear),
        .i_n     (eff_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_open  (i_open_price),
        .i_close (i_close_price),
        .o_push  (job_push),
        .o_job   (job_in),
        .i_full  (job_full)
    );

    swsb_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    swsb_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (eff_n),
        .i_cfg          (r_cfg),
        .i_job          (job_out),
        .i_empty        (job_empty),
        .o_pop          (job_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_open_echo    (o_open_echo),
        .o_close_echo   (o_close_echo),
        .o_window_mean  (o_window_mean),
        .o_window_sigma (o_window_sigma),
        .o_outer_low    (o_outer_low),
        .o_inner_low    (o_inner_low),
        .o_inner_high   (o_inner_high),
        .o_outer_high   (o_outer_high)
    );

endmodule
